// ===== rtl/core/pws_pkg.sv =====
// Shared types and constants for the piecewise power waveshaper.
`default_nettype none
package pws_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_KNEE1_X       = 3'd0,
        CFG_KNEE1_Y       = 3'd1,
        CFG_KNEE2_X       = 3'd2,
        CFG_KNEE2_Y       = 3'd3,
        CFG_EXPONENT_LOW  = 3'd4,
        CFG_EXPONENT_MID  = 3'd5,
        CFG_EXPONENT_HIGH = 3'd6,
        CFG_MIX_AMOUNT    = 3'd7
    } t_cfg_reg;

    // Register reset values
    localparam logic [15:0] RST_KNEE1_X  = 16'd6554;
    localparam logic [16:0] RST_KNEE1_Y  = 17'd6554;
    localparam logic [15:0] RST_KNEE2_X  = 16'd19661;
    localparam logic [16:0] RST_KNEE2_Y  = 17'd19661;
    localparam logic [16:0] RST_EXPONENT = 17'd4096;
    localparam logic [16:0] RST_MIX      = 17'd65536;

    // Clamp limits
    localparam logic [15:0] KNEE_MIN  = 16'd66;
    localparam logic [15:0] KNEE_MAX  = 16'd65470;
    localparam logic [16:0] LEVEL_MAX = 17'd65536;
    localparam logic [16:0] EXP_MIN   = 17'd256;
    localparam logic [16:0] EXP_MAX   = 17'd65536;

    // Fixed-point constants
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [25:0] D_LIMIT = 26'd2097152;

    // Reciprocals floor(2^32 / n) for the series divisors, n = 1..8
    localparam logic [32:0] RECIP [1:8] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912
    };

endpackage
`default_nettype wire

// ===== rtl/core/piecewise_power_waveshaper.sv =====
// Piecewise power-curve waveshaper: three-segment shaping with dry/wet mix.
`default_nettype none
// One sample enters every cycle while the pipeline is not held; the pipeline
// holds a bit-per-stage quotient (32 stages), sixteen log2 squaring stages
// and an eight-term exp2 series at three stages a term. All stages advance
// together: while a finished word waits at the output and the sink holds
// tready low, the whole pipeline holds and the input is not taken. Write the
// configuration only while no samples are in flight.
module piecewise_power_waveshaper #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // stream in
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_tdata,  // sample_in, zero pad
    input  wire                                  i_s_tlast,  // last_in
    // stream out
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    o_m_tdata,  // sample_out, zero pad
    output logic                                 o_m_tlast,  // last_out
    // configuration write
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [2:0]                           i_cfg_index,
    input  wire  [16:0]                          i_cfg_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int BW    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SH    = 33 - SAMPLE_WIDTH;
    localparam int AW    = SAMPLE_WIDTH + 21;
    localparam int NDIV  = 31;
    localparam int NSQ   = 16;
    localparam int NTERM = 8;
    localparam int S_DIV = 3;
    localparam int S_LEAD = S_DIV + NDIV;
    localparam int S_SQ  = S_LEAD + 2;
    localparam int S_D   = S_SQ + NSQ;
    localparam int S_HOR = S_D + 3;
    localparam int S_PW  = S_HOR + 3 * NTERM;
    localparam int LAST  = S_PW + 4;

    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic signed [SW-1:0]  dry;
        logic                  neg;
        logic [16:0]           lo;
        logic [16:0]           hi;
        logic [16:0]           p;
        logic [32:0]           num;
        logic [32:0]           den;
        logic [32:0]           rem;
        logic [31:0]           quo;
        logic                  zf;
        logic                  ovr;
        logic [4:0]            lead;
        logic [31:0]           m;
        logic [15:0]           lfrac;
        logic [25:0]           d;
        logic                  dz;
        logic [4:0]            k;
        logic [16:0]           u;
        logic [29:0]           b;
        logic [31:0]           r;
        logic [31:0]           y;
        logic [31:0]           q0;
        logic [31:0]           pw;
        logic [32:0]           prod;
        logic                  up;
        logic [SW:0]           wet;
        logic signed [AW-1:0]  pa;
        logic signed [AW-1:0]  pb;
        logic signed [SW-1:0]  res;
    } t_stage;

    // Configuration registers
    logic [15:0] r_knee1_x, r_knee2_x;
    logic [16:0] r_knee1_y, r_knee2_y;
    logic [16:0] r_exp_low, r_exp_mid, r_exp_high, r_mix;

    t_stage r_pipe [0:LAST];
    t_stage n_pipe [0:LAST];

    logic en;

    // Derived, clamped settings
    logic [15:0] k1, k2;
    logic [16:0] v1, v2, mixc, minv;
    logic [32:0] a1, a2;

    assign o_cfg_ready = 1'b1;

    // Take configuration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knee1_x  <= pws_pkg::RST_KNEE1_X;
            r_knee1_y  <= pws_pkg::RST_KNEE1_Y;
            r_knee2_x  <= pws_pkg::RST_KNEE2_X;
            r_knee2_y  <= pws_pkg::RST_KNEE2_Y;
            r_exp_low  <= pws_pkg::RST_EXPONENT;
            r_exp_mid  <= pws_pkg::RST_EXPONENT;
            r_exp_high <= pws_pkg::RST_EXPONENT;
            r_mix      <= pws_pkg::RST_MIX;
        end else if (i_cfg_valid) begin
            case (pws_pkg::t_cfg_reg'(i_cfg_index))
                pws_pkg::CFG_KNEE1_X:       r_knee1_x  <= i_cfg_data[15:0];
                pws_pkg::CFG_KNEE1_Y:       r_knee1_y  <= i_cfg_data;
                pws_pkg::CFG_KNEE2_X:       r_knee2_x  <= i_cfg_data[15:0];
                pws_pkg::CFG_KNEE2_Y:       r_knee2_y  <= i_cfg_data;
                pws_pkg::CFG_EXPONENT_LOW:  r_exp_low  <= i_cfg_data;
                pws_pkg::CFG_EXPONENT_MID:  r_exp_mid  <= i_cfg_data;
                pws_pkg::CFG_EXPONENT_HIGH: r_exp_high <= i_cfg_data;
                pws_pkg::CFG_MIX_AMOUNT:    r_mix      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp knees, levels and mix
    always_comb begin
        k1 = r_knee1_x;
        if (k1 < pws_pkg::KNEE_MIN) k1 = pws_pkg::KNEE_MIN;
        if (k1 > pws_pkg::KNEE_MAX) k1 = pws_pkg::KNEE_MAX;
        k2 = r_knee2_x;
        if (k2 < k1) k2 = k1;
        if (k2 > pws_pkg::KNEE_MAX) k2 = pws_pkg::KNEE_MAX;
        a1 = {1'b0, k1, 16'd0};
        a2 = {1'b0, k2, 16'd0};
        v1 = (r_knee1_y > pws_pkg::LEVEL_MAX) ? pws_pkg::LEVEL_MAX : r_knee1_y;
        v2 = (r_knee2_y > pws_pkg::LEVEL_MAX) ? pws_pkg::LEVEL_MAX : r_knee2_y;
        mixc = (r_mix > pws_pkg::LEVEL_MAX) ? pws_pkg::LEVEL_MAX : r_mix;
        minv = pws_pkg::LEVEL_MAX - mixc;
    end

    // Advance all stages together unless the output word is held
    assign en         = !r_pipe[LAST].vld || i_m_tready;
    assign o_s_tready = en;

    // Stage logic
    always_comb begin
        t_stage              s;
        logic [SW-1:0]       mag;
        logic [32:0]         xpos;
        logic [16:0]         pc;
        logic [33:0]         rem2;
        logic [63:0]         sq;
        logic [20:0]         q;
        logic [37:0]         qp;
        logic [48:0]         ub;
        logic [61:0]         br;
        logic [64:0]         ym;
        logic [35:0]         qn;
        logic [32:0]         rm;
        logic [31:0]         pwt;
        logic [16:0]         diff;
        logic [48:0]         pd;
        logic [33:0]         shaped;
        logic signed [AW-1:0] wets;
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] sh16;
        logic [3:0]          nn;

        // capture
        n_pipe[0]      = r_pipe[0];
        n_pipe[0].vld  = i_s_tvalid;
        n_pipe[0].last = i_s_tlast;
        n_pipe[0].dry  = $signed(i_s_tdata[SW-1:0]);

        // pick segment
        s   = r_pipe[0];
        mag = s.dry[SW-1] ? SW'(-s.dry) : SW'(s.dry);
        xpos = 33'(mag) << SH;
        if (xpos <= a1) begin
            s.num = xpos;      s.den = a1;
            s.lo = 17'd0;      s.hi = v1;   pc = r_exp_low;
        end else if (xpos <= a2) begin
            s.num = xpos - a1; s.den = a2 - a1;
            s.lo = v1;         s.hi = v2;   pc = r_exp_mid;
        end else begin
            s.num = xpos - a2; s.den = pws_pkg::ONE_Q32 - a2;
            s.lo = v2;         s.hi = pws_pkg::LEVEL_MAX; pc = r_exp_high;
        end
        if (pc < pws_pkg::EXP_MIN) pc = pws_pkg::EXP_MIN;
        if (pc > pws_pkg::EXP_MAX) pc = pws_pkg::EXP_MAX;
        s.p   = pc;
        s.neg = s.dry[SW-1];
        n_pipe[1] = s;

        // quotient top bit
        s = r_pipe[1];
        if (s.num >= s.den) begin
            s.quo = 32'd1; s.rem = s.num - s.den;
        end else begin
            s.quo = 32'd0; s.rem = s.num;
        end
        n_pipe[2] = s;

        // one quotient bit per stage
        for (int i = 0; i < NDIV; i++) begin
            s    = r_pipe[S_DIV + i - 1];
            rem2 = {s.rem, 1'b0};
            if (rem2 >= {1'b0, s.den}) begin
                s.rem = 33'(rem2 - {1'b0, s.den});
                s.quo = {s.quo[30:0], 1'b1};
            end else begin
                s.rem = rem2[32:0];
                s.quo = {s.quo[30:0], 1'b0};
            end
            n_pipe[S_DIV + i] = s;
        end

        // find the leading one
        s      = r_pipe[S_LEAD - 1];
        s.zf   = (s.quo == 32'd0);
        s.ovr  = s.quo[31];
        s.lead = 5'd0;
        for (int j = 0; j < 31; j++) begin
            if (s.quo[j]) s.lead = 5'(j);
        end
        n_pipe[S_LEAD] = s;

        // normalise the mantissa
        s   = r_pipe[S_LEAD];
        s.m = s.quo << (5'd31 - s.lead);
        s.lfrac = 16'd0;
        n_pipe[S_LEAD + 1] = s;

        // squaring steps for the log2 fraction
        for (int i = 0; i < NSQ; i++) begin
            s  = r_pipe[S_SQ + i - 1];
            sq = 64'(s.m) * 64'(s.m);
            if (sq[63]) begin
                s.lfrac = {s.lfrac[14:0], 1'b1};
                s.m     = sq[63:32];
            end else begin
                s.lfrac = {s.lfrac[14:0], 1'b0};
                s.m     = sq[62:31];
            end
            n_pipe[S_SQ + i] = s;
        end

        // scale the negated log by the exponent
        s   = r_pipe[S_D - 1];
        q   = {5'd31 - s.lead, 16'd0} - 21'(s.lfrac);
        qp  = 38'(q) * 38'(s.p) + 38'd2048;
        s.d = qp[37:12];
        n_pipe[S_D] = s;

        // split into shift and fraction
        s    = r_pipe[S_D];
        s.dz = (s.d >= pws_pkg::D_LIMIT);
        s.k  = s.d[20:16];
        s.u  = pws_pkg::LEVEL_MAX - {1'b0, s.d[15:0]};
        n_pipe[S_D + 1] = s;

        // series argument
        s   = r_pipe[S_D + 1];
        ub  = 49'(s.u) * 49'(pws_pkg::LN2_Q32);
        s.b = ub[47:18];
        s.r = pws_pkg::ONE_Q30;
        n_pipe[S_D + 2] = s;

        // Horner terms, three stages each
        for (int t = 0; t < NTERM; t++) begin
            nn = 4'(NTERM - t);
            s  = r_pipe[S_HOR + 3 * t - 1];
            br = 62'(s.b) * 62'(s.r);
            s.y = br[61:30];
            n_pipe[S_HOR + 3 * t] = s;

            s  = r_pipe[S_HOR + 3 * t];
            ym = 65'(s.y) * 65'(pws_pkg::RECIP[NTERM - t]);
            s.q0 = ym[63:32];
            n_pipe[S_HOR + 3 * t + 1] = s;

            s  = r_pipe[S_HOR + 3 * t + 1];
            qn = 36'(s.q0) * 36'(nn);
            rm = 33'(36'(s.y) - qn);
            if (rm >= 33'(nn)) s.q0 = s.q0 + 32'd1;
            s.r = pws_pkg::ONE_Q30 + s.q0;
            n_pipe[S_HOR + 3 * t + 2] = s;
        end

        // power, shifted and capped
        s   = r_pipe[S_PW - 1];
        pwt = s.r >> s.k;
        if (pwt > pws_pkg::ONE_Q31) pwt = pws_pkg::ONE_Q31;
        if (s.dz || s.zf) pwt = 32'd0;
        if (s.ovr) pwt = pws_pkg::ONE_Q31;
        s.pw = pwt;
        n_pipe[S_PW] = s;

        // scale by the segment span
        s    = r_pipe[S_PW];
        s.up = (s.hi >= s.lo);
        diff = s.up ? (s.hi - s.lo) : (s.lo - s.hi);
        pd   = 49'(s.pw) * 49'(diff);
        s.prod = pd[47:15];
        n_pipe[S_PW + 1] = s;

        // add the base level and round to sample scale
        s = r_pipe[S_PW + 1];
        if (s.up) shaped = {1'b0, s.lo, 16'd0} + 34'(s.prod);
        else      shaped = {1'b0, s.lo, 16'd0} - 34'(s.prod);
        shaped = (shaped + (34'd1 << (SH - 1))) >> SH;
        s.wet  = shaped[SW:0];
        n_pipe[S_PW + 2] = s;

        // dry and wet products
        s    = r_pipe[S_PW + 2];
        wets = s.neg ? -$signed(AW'(s.wet)) : $signed(AW'(s.wet));
        s.pa = AW'(s.dry) * $signed(AW'(minv));
        s.pb = wets * $signed(AW'(mixc));
        n_pipe[S_PW + 3] = s;

        // sum, round and saturate
        s    = r_pipe[S_PW + 3];
        acc  = s.pa + s.pb + AW'(32768);
        sh16 = acc >>> 16;
        if (sh16 > $signed(AW'({1'b0, {(SW-1){1'b1}}})))
            s.res = {1'b0, {(SW-1){1'b1}}};
        else if (sh16 < -$signed(AW'({1'b1, {(SW-1){1'b0}}})))
            s.res = {1'b1, {(SW-1){1'b0}}};
        else
            s.res = sh16[SW-1:0];
        n_pipe[LAST] = s;
    end

    // Pipeline registers; reset drops valid only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) r_pipe[i].vld <= 1'b0;
        end else if (en) begin
            for (int i = 0; i <= LAST; i++) r_pipe[i] <= n_pipe[i];
        end
    end

    assign o_m_tvalid = r_pipe[LAST].vld;
    assign o_m_tlast  = r_pipe[LAST].last;
    assign o_m_tdata  = BW'($unsigned(r_pipe[LAST].res));

endmodule
`default_nettype wire

// ===== dv/pws_checker.sv =====
// Checker for the piecewise power waveshaper: predicts each output word and compares.
`timescale 1ns / 100ps
module pws_checker #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_s_tvalid,
    input  wire                                  i_s_tready,
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input  wire                                  i_s_tlast,
    input  wire                                  i_m_tvalid,
    input  wire                                  i_m_tready,
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]    i_m_tdata,
    input  wire                                  i_m_tlast,
    input  wire                                  i_cfg_valid,
    input  wire                                  i_cfg_ready,
    input  wire  [2:0]                           i_cfg_index,
    input  wire  [16:0]                          i_cfg_data,
    output int                                   o_errors,
    output int                                   o_pending,
    output int                                   o_checked
);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    last;
    } t_shaped_word;

    t_shaped_word shaped_q[$];

    logic [15:0] k1x, k2x;
    logic [16:0] k1y, k2y, p_low, p_mid, p_high, mix_reg;

    localparam int SH = 33 - SAMPLE_WIDTH;

    function automatic logic [63:0] clamp64(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Raise a Q1.31 position to a Q5.12 exponent via log2 and exp2
    function automatic logic [63:0] power_q31(logic [63:0] t, logic [63:0] p);
        int          lead;
        logic [63:0] m, lfrac, q, d, k, u, b, r, pw;
        lead  = 30;
        lfrac = 0;
        if (t == 0) return 0;
        if (t >= 64'h8000_0000) return 64'h8000_0000;
        while (t[lead] == 1'b0) lead--;
        m = t << (31 - lead);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            lfrac = lfrac << 1;
            if (m >= 64'h1_0000_0000) begin
                lfrac = lfrac | 1;
                m = m >> 1;
            end
        end
        q = 64'(31 - lead) * 65536 - lfrac;
        d = (q * p + 2048) >> 12;
        if (d >= 64'd2097152) return 0;
        k = d >> 16;
        u = 65536 - (d & 64'hFFFF);
        b = (u * 64'(pws_pkg::LN2_Q32)) >> 18;
        r = 64'h4000_0000;
        for (int n = 8; n >= 1; n--)
            r = 64'h4000_0000 + ((b * r) >> 30) / 64'(n);
        pw = r >> k;
        if (pw > 64'h8000_0000) pw = 64'h8000_0000;
        return pw;
    endfunction

    // Shape one sample through the knee curve and the dry/wet crossfade
    function automatic t_shaped_word shape_sample(logic [SAMPLE_WIDTH-1:0] raw, logic last);
        t_shaped_word          w;
        logic signed [63:0]    dry, wet_s, acc, res, top;
        logic                  neg;
        logic [63:0]           mag, xpos, k1, k2, a1, a2, v1, v2;
        logic [63:0]           num, den, lo, hi, p, t, pw, shaped, wet, mx;
        dry  = 64'(signed'(raw));
        top  = 64'sd1 <<< (SAMPLE_WIDTH - 1);
        neg  = dry < 0;
        mag  = neg ? 64'(-dry) : 64'(dry);
        xpos = mag << SH;
        k1 = clamp64(64'(k1x), 66, 65470);
        k2 = clamp64(64'(k2x), k1, 65470);
        a1 = k1 << 16;
        a2 = k2 << 16;
        v1 = k1y > 65536 ? 64'd65536 : 64'(k1y);
        v2 = k2y > 65536 ? 64'd65536 : 64'(k2y);
        if (xpos <= a1) begin
            num = xpos; den = a1; lo = 0; hi = v1; p = 64'(p_low);
        end else if (xpos <= a2) begin
            num = xpos - a1; den = a2 - a1; lo = v1; hi = v2; p = 64'(p_mid);
        end else begin
            num = xpos - a2; den = 64'h1_0000_0000 - a2; lo = v2; hi = 65536;
            p = 64'(p_high);
        end
        p  = clamp64(p, 256, 65536);
        t  = (num << 31) / den;
        pw = power_q31(t, p);
        if (hi >= lo) shaped = (lo << 16) + ((pw * (hi - lo)) >> 15);
        else shaped = (lo << 16) - ((pw * (lo - hi)) >> 15);
        wet   = (shaped + (64'd1 << (SH - 1))) >> SH;
        wet_s = neg ? -signed'(wet) : signed'(wet);
        mx    = mix_reg > 65536 ? 64'd65536 : 64'(mix_reg);
        acc   = dry * signed'(65536 - mx) + wet_s * signed'(mx) + 32768;
        if (acc >= 0) res = acc / 65536;
        else res = -((-acc + 65535) / 65536);
        if (res > top - 1) res = top - 1;
        if (res < -top) res = -top;
        w.sample = res[SAMPLE_WIDTH-1:0];
        w.last   = last;
        return w;
    endfunction

    // Track registers, queue predictions, compare output words
    always @(posedge i_clk) begin
        t_shaped_word exp_w;
        int           mism;
        mism = 0;
        if (!i_rst_n) begin
            k1x <= pws_pkg::RST_KNEE1_X;  k1y <= pws_pkg::RST_KNEE1_Y;
            k2x <= pws_pkg::RST_KNEE2_X;  k2y <= pws_pkg::RST_KNEE2_Y;
            p_low  <= pws_pkg::RST_EXPONENT;
            p_mid  <= pws_pkg::RST_EXPONENT;
            p_high <= pws_pkg::RST_EXPONENT;
            mix_reg <= pws_pkg::RST_MIX;
            shaped_q.delete();
            o_errors  <= 0;
            o_checked <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (pws_pkg::t_cfg_reg'(i_cfg_index))
                    pws_pkg::CFG_KNEE1_X:       k1x <= i_cfg_data[15:0];
                    pws_pkg::CFG_KNEE1_Y:       k1y <= i_cfg_data;
                    pws_pkg::CFG_KNEE2_X:       k2x <= i_cfg_data[15:0];
                    pws_pkg::CFG_KNEE2_Y:       k2y <= i_cfg_data;
                    pws_pkg::CFG_EXPONENT_LOW:  p_low <= i_cfg_data;
                    pws_pkg::CFG_EXPONENT_MID:  p_mid <= i_cfg_data;
                    pws_pkg::CFG_EXPONENT_HIGH: p_high <= i_cfg_data;
                    pws_pkg::CFG_MIX_AMOUNT:    mix_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                shaped_q.push_back(shape_sample(i_s_tdata[SAMPLE_WIDTH-1:0], i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                o_checked <= o_checked + 1;
                if (shaped_q.size() == 0) begin
                    $error("output word with nothing expected: sample_out=%0d",
                           $signed(i_m_tdata[SAMPLE_WIDTH-1:0]));
                    mism++;
                end else begin
                    exp_w = shaped_q.pop_front();
                    if (exp_w.sample !== i_m_tdata[SAMPLE_WIDTH-1:0]) begin
                        $error("sample_out: expected %0d, actual %0d",
                               $signed(exp_w.sample), $signed(i_m_tdata[SAMPLE_WIDTH-1:0]));
                        mism++;
                    end
                    if (exp_w.last !== i_m_tlast) begin
                        $error("last_out: expected %0b, actual %0b", exp_w.last, i_m_tlast);
                        mism++;
                    end
                end
            end
            o_errors  <= o_errors + mism;
            o_pending <= shaped_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus and verdict for the piecewise power waveshaper testbench.
`timescale 1ns / 100ps
module tb_top;

    localparam int SW       = 24;
    localparam int DW       = ((SW + 7) / 8) * 8;
    localparam int LATENCY  = 84;
    localparam int WDOG_MAX = 5000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tlast = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic          m_tlast;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [16:0]   cfg_data = '0;
    int            errors, pending, checked;
    int            send_idle_pct = 0, recv_idle_pct = 0;
    int            samples_sent = 0, cfg_sets = 0;
    int            quiet_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    piecewise_power_waveshaper #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    pws_checker #(.SAMPLE_WIDTH(SW)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    // Receiver stalls at random
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d words outstanding", pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one register word; the caller drops valid after the last one
    task automatic write_reg(pws_pkg::t_cfg_reg idx, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Hold until every expected word is back, then let the pipe drain
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one sample; valid stays up so the next word can follow directly
    task automatic send_sample(logic [SW-1:0] smp, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'(smp);
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic load_curve(logic [15:0] k1x, logic [16:0] k1y, logic [15:0] k2x,
                              logic [16:0] k2y, logic [16:0] pl, logic [16:0] pm,
                              logic [16:0] ph, logic [16:0] mx);
        drain_pipe();
        write_reg(pws_pkg::CFG_KNEE1_X, 17'(k1x));
        write_reg(pws_pkg::CFG_KNEE1_Y, k1y);
        write_reg(pws_pkg::CFG_KNEE2_X, 17'(k2x));
        write_reg(pws_pkg::CFG_KNEE2_Y, k2y);
        write_reg(pws_pkg::CFG_EXPONENT_LOW, pl);
        write_reg(pws_pkg::CFG_EXPONENT_MID, pm);
        write_reg(pws_pkg::CFG_EXPONENT_HIGH, ph);
        write_reg(pws_pkg::CFG_MIX_AMOUNT, mx);
        cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    // Random sample biased towards the extremes and values near zero
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return SW'($urandom_range(255));
            3: return -SW'($urandom_range(256));
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic random_burst(int count);
        for (int n = 0; n < count; n++)
            send_sample(pick_sample(), ($urandom_range(7) == 0));
    endtask

    task automatic random_curve();
        logic [15:0] a, b;
        a = 16'($urandom_range(65535));
        b = 16'($urandom_range(65535));
        if ($urandom_range(3) == 0) b = a;
        else if (a > b && $urandom_range(3) != 0) begin
            a = a ^ b; b = a ^ b; a = a ^ b;
        end
        load_curve(a, 17'($urandom_range(70000)), b, 17'($urandom_range(70000)),
                   17'($urandom_range(131071)), 17'($urandom_range(70000)),
                   17'($urandom_range(4096, 20000)), 17'($urandom_range(70000)));
    endtask

    initial begin
        logic [SW-1:0] directed [$];
        directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                     24'h800001, 24'h0CCCCD, 24'hF33333, 24'h266666, 24'hD9999A,
                     24'h555555, 24'hAAAAAA, 24'h400000, 24'hC00000, 24'h0CCCCC,
                     24'h266667};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset curve, then out-of-range and degenerate settings
        recv_idle_pct = 0;
        foreach (directed[i]) send_sample(directed[i], i[0]);
        load_curve(16'hFFFF, 17'h1FFFF, 16'h0000, 17'h1FFFF, 17'h1FFFF, 17'd0,
                   17'd255, 17'h1FFFF);
        foreach (directed[i]) send_sample(directed[i], 1'b1);
        load_curve(16'd30000, 17'd60000, 16'd30000, 17'd1000, 17'd256, 17'd65536,
                   17'd65536, 17'd0);
        random_burst(8);
        load_curve(16'd66, 17'd0, 16'd65470, 17'd65536, 17'd65536, 17'd256,
                   17'd256, 17'd32768);
        random_burst(8);

        // Random phases: receiver idles more, then sender idles more, then neither
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 31 : 0;
            for (int c = 0; c < 5; c++) begin
                random_curve();
                random_burst(65);
            end
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;

        drain_pipe();
        $display("covered %0d samples over %0d curve settings, %0d words checked",
                 samples_sent, cfg_sets, checked);
        $display("settings included clamped knees, equal knees, falling levels, dry and wet");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== piecewise_power_waveshaper.f =====
rtl/core/pws_pkg.sv
rtl/core/piecewise_power_waveshaper.sv
dv/pws_checker.sv
dv/tb_top.sv
